// ----- src/mvna_pkg.sv -----
// shared types and constants of the vertex normal accumulator
package mvna_pkg;

   localparam int MaxVertices = 1024;
   localparam int IdxW        = $clog2(MaxVertices);
   localparam int CountW      = 11;
   localparam int CoordW      = 32;
   localparam int NormW       = 16;
   localparam int SumW        = 24;
   localparam int EdgeW       = CoordW + 1;
   localparam int ProdW       = 2 * EdgeW;
   localparam int CrossW      = ProdW + 1;
   localparam int MagW        = ProdW;
   localparam int UnitW       = 30;
   localparam int SqW         = 62;
   localparam int RootW       = 31;
   localparam int FracW       = 15;
   localparam int NumW        = UnitW + FracW + 1;
   localparam int QuotW       = NumW - UnitW + 1;
   localparam int WideW       = 64;
   localparam int VertW       = 3 * CoordW;
   localparam int SumRowW     = 3 * SumW;

   localparam logic signed [SumW-1:0] AccMax = {1'b0, {(SumW-1){1'b1}}};
   localparam logic signed [SumW-1:0] AccMin = {1'b1, {(SumW-1){1'b0}}};
   localparam logic [NormW-1:0] QuotCap = {1'b0, {(NormW-1){1'b1}}};

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_FACE  = 2'd1,
      ACT_READ  = 2'd2,
      ACT_CLEAR = 2'd3
   } mvna_action_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_DEGEN = 2'd2
   } mvna_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_FETCH,
      S_CROSS,
      S_MAG,
      S_SUMRD,
      S_NORM,
      S_SQ,
      S_ROOT_GO,
      S_ROOT_WAIT,
      S_DIV_GO,
      S_DIV_WAIT,
      S_ACC,
      S_CLEAR,
      S_RESP
   } mvna_state_type;

   typedef struct packed {
      mvna_action_type    action;
      logic [IdxW-1:0]    index_a;
      logic [IdxW-1:0]    index_b;
      logic [IdxW-1:0]    index_c;
      logic signed [CoordW-1:0] coord_x;
      logic signed [CoordW-1:0] coord_y;
      logic signed [CoordW-1:0] coord_z;
   } mvna_req_type;

   typedef struct packed {
      logic signed [NormW-1:0] normal_x;
      logic signed [NormW-1:0] normal_y;
      logic signed [NormW-1:0] normal_z;
      mvna_status_type         status;
   } mvna_rsp_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } mvna_rdiv_cmd_type;

endpackage

// ----- src/mesh_vertex_normal_accumulator_unit.sv -----
// top level: per-vertex averaged unit normals of a triangle mesh
//
//  channel  direction  handshake            contents
//  req_     in         req_valid/req_ready  action, three indices, vertex coordinates
//  rsp_     out        rsp_valid/rsp_ready  three q1.15 normal components, status
//  csr_     in         csr_wr_en            vertex_count, written without wait
//
// one item at a time; req_ready is high only in the idle state
// add face and read durations are set by the one-bit normalizing shifter, the square
//   root and three divisions of the shared root/divide unit
// clear zeroes one accumulator row per cycle, all 1024 rows
// after reset the same clearing pass runs before the first transfer is taken
// the result register lets the next request in while a response waits for rsp_ready
module mesh_vertex_normal_accumulator_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mvna_pkg::mvna_req_type              req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mvna_pkg::mvna_rsp_type              rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [mvna_pkg::CountW-1:0]         csr_wr_data
);

   localparam int IdxW   = mvna_pkg::IdxW;
   localparam int EdgeW  = mvna_pkg::EdgeW;
   localparam int CrossW = mvna_pkg::CrossW;
   localparam int MagW   = mvna_pkg::MagW;
   localparam int SumW   = mvna_pkg::SumW;
   localparam int CoordW = mvna_pkg::CoordW;
   localparam int NormW  = mvna_pkg::NormW;
   localparam int UnitW  = mvna_pkg::UnitW;

   // control state
   mvna_pkg::mvna_state_type state_ff, state_in;
   logic [IdxW-1:0]          clr_cnt_ff, clr_cnt_in;
   logic                     clr_rsp_ff, clr_rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [mvna_pkg::CountW-1:0] vcount_ff, vcount_in;

   // datapath registers
   mvna_pkg::mvna_req_type   req_ff, req_in;
   mvna_pkg::mvna_rsp_type   rsp_ff, rsp_in;
   mvna_pkg::mvna_status_type status_ff, status_in;
   logic [2:0]               step_ff, step_in;
   logic [1:0]               comp_ff, comp_in;
   logic signed [CoordW-1:0] va_ff [3], va_in [3];
   logic signed [EdgeW-1:0]  e1_ff [3], e1_in [3];
   logic signed [EdgeW-1:0]  e2_ff [3], e2_in [3];
   logic signed [CrossW-1:0] c_ff [3], c_in [3];
   logic [MagW-1:0]          mag_ff [3], mag_in [3];
   logic                     neg_ff [3], neg_in [3];
   logic [mvna_pkg::SqW-1:0] s_ff, s_in;
   logic [mvna_pkg::RootW-1:0] r_ff, r_in;
   logic signed [NormW-1:0]  u_ff [3], u_in [3];

   // memories
   logic                         vram_we;
   logic [IdxW-1:0]              vram_raddr;
   logic [mvna_pkg::VertW-1:0]   vram_wdata, vram_rdata;
   logic                         sram_we;
   logic [IdxW-1:0]              sram_waddr, sram_raddr;
   logic [mvna_pkg::SumRowW-1:0] sram_wdata, sram_rdata;

   // shared units
   logic signed [EdgeW-1:0]           mul_a, mul_b;
   logic signed [mvna_pkg::ProdW-1:0] prod;
   mvna_pkg::mvna_rdiv_cmd_type       rdiv_cmd;
   logic [mvna_pkg::NumW-1:0]         rdiv_num;
   logic                              rdiv_done;
   logic [mvna_pkg::RootW-1:0]        rdiv_res;

   // decode helpers
   logic                     bad_a, bad_b, bad_c;
   logic [MagW-1:0]          or_mag;
   logic [2:0]               jsel;
   logic [1:0]               jcomp;
   logic signed [CrossW-1:0] prod_ext;

   function automatic logic [IdxW-1:0] corner(input mvna_pkg::mvna_req_type rq,
                                              input logic [1:0] sel);
      logic [IdxW-1:0] idx;
      case (sel)
         2'd1:    idx = rq.index_b;
         2'd2:    idx = rq.index_c;
         default: idx = rq.index_a;
      endcase
      return idx;
   endfunction

   function automatic logic signed [SumW-1:0] sat_add(input logic signed [SumW-1:0] a,
                                                     input logic signed [NormW-1:0] b);
      logic signed [SumW:0] t;
      logic signed [SumW-1:0] res;
      t = {a[SumW-1], a} + (SumW+1)'(b);
      if (t > (SumW+1)'(mvna_pkg::AccMax)) begin
         res = mvna_pkg::AccMax;
      end else if (t < (SumW+1)'(mvna_pkg::AccMin)) begin
         res = mvna_pkg::AccMin;
      end else begin
         res = t[SumW-1:0];
      end
      return res;
   endfunction

   mvna_ram #(
      .Width (mvna_pkg::VertW),
      .Depth (mvna_pkg::MaxVertices)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (vram_we),
      .wr_addr (req_ff.index_a),
      .wr_data (vram_wdata),
      .rd_addr (vram_raddr),
      .rd_data (vram_rdata)
   );

   mvna_ram #(
      .Width (mvna_pkg::SumRowW),
      .Depth (mvna_pkg::MaxVertices)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (sram_we),
      .wr_addr (sram_waddr),
      .wr_data (sram_wdata),
      .rd_addr (sram_raddr),
      .rd_data (sram_rdata)
   );

   mvna_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   mvna_rdiv u_rdiv (
      .clock    (clock),
      .reset    (reset),
      .cmd      (rdiv_cmd),
      .radicand (s_ff),
      .numer    (rdiv_num),
      .denom    (r_ff),
      .done     (rdiv_done),
      .result   (rdiv_res)
   );

   // index checks; counts above the depth accept every index
   assign bad_a = {1'b0, req_ff.index_a} >= vcount_ff;
   assign bad_b = {1'b0, req_ff.index_b} >= vcount_ff;
   assign bad_c = {1'b0, req_ff.index_c} >= vcount_ff;

   assign or_mag     = mag_ff[0] | mag_ff[1] | mag_ff[2];
   assign vram_wdata = {req_ff.coord_x, req_ff.coord_y, req_ff.coord_z};
   assign jsel       = step_ff - 3'd1;
   assign jcomp      = jsel[2:1];
   assign prod_ext   = {prod[mvna_pkg::ProdW-1], prod};
   // rounding numerator: m * 2^15 + r / 2
   assign rdiv_num   = {1'b0, mag_ff[comp_ff][UnitW-1:0], {mvna_pkg::FracW{1'b0}}}
                       + mvna_pkg::NumW'(r_ff >> 1);

   always_comb begin
      logic signed [CrossW-1:0] cneg;
      logic signed [SumW:0]     sext;
      logic signed [SumW:0]     sabs;
      logic [NormW-1:0]         qcap;
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      vcount_in    = csr_wr_en ? csr_wr_data : vcount_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      status_in    = status_ff;
      step_in      = step_ff;
      comp_in      = comp_ff;
      va_in        = va_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      c_in         = c_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      s_in         = s_ff;
      r_in         = r_ff;
      u_in         = u_ff;
      vram_we      = 1'b0;
      vram_raddr   = corner(req_ff, step_ff[1:0]);
      sram_we      = 1'b0;
      sram_waddr   = corner(req_ff, jsel[1:0]);
      sram_wdata   = '0;
      sram_raddr   = corner(req_ff, step_ff[1:0]);
      mul_a        = '0;
      mul_b        = '0;
      rdiv_cmd     = '0;
      req_ready    = 1'b0;
      cneg         = '0;
      sext         = '0;
      sabs         = '0;
      qcap         = '0;

      unique case (state_ff)
         mvna_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_payload;
               state_in = mvna_pkg::S_DECODE;
            end
         end

         mvna_pkg::S_DECODE: begin
            status_in = mvna_pkg::STAT_OK;
            for (int i = 0; i < 3; i++) begin
               u_in[i] = '0;
            end
            step_in    = '0;
            sram_raddr = req_ff.index_a;
            unique case (req_ff.action)
               mvna_pkg::ACT_WRITE: begin
                  if (bad_a) begin
                     status_in = mvna_pkg::STAT_RANGE;
                  end else begin
                     vram_we = 1'b1;
                  end
                  state_in = mvna_pkg::S_RESP;
               end
               mvna_pkg::ACT_FACE: begin
                  if (bad_a || bad_b || bad_c) begin
                     status_in = mvna_pkg::STAT_RANGE;
                     state_in  = mvna_pkg::S_RESP;
                  end else if (req_ff.index_a == req_ff.index_b ||
                               req_ff.index_b == req_ff.index_c ||
                               req_ff.index_c == req_ff.index_a) begin
                     status_in = mvna_pkg::STAT_DEGEN;
                     state_in  = mvna_pkg::S_RESP;
                  end else begin
                     state_in = mvna_pkg::S_FETCH;
                  end
               end
               mvna_pkg::ACT_READ: begin
                  if (bad_a) begin
                     status_in = mvna_pkg::STAT_RANGE;
                     state_in  = mvna_pkg::S_RESP;
                  end else begin
                     state_in = mvna_pkg::S_SUMRD;
                  end
               end
               mvna_pkg::ACT_CLEAR: begin
                  clr_cnt_in = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = mvna_pkg::S_CLEAR;
               end
               default: state_in = mvna_pkg::S_RESP;
            endcase
         end

         // corners read one per cycle, edges formed as data returns
         mvna_pkg::S_FETCH: begin
            step_in = step_ff + 3'd1;
            for (int i = 0; i < 3; i++) begin
               case (step_ff)
                  3'd1: va_in[i] = vram_rdata[CoordW*(2-i) +: CoordW];
                  3'd2: e1_in[i] = {vram_rdata[CoordW*(3-i)-1],
                                    vram_rdata[CoordW*(2-i) +: CoordW]}
                                   - {va_ff[i][CoordW-1], va_ff[i]};
                  3'd3: e2_in[i] = {vram_rdata[CoordW*(3-i)-1],
                                    vram_rdata[CoordW*(2-i) +: CoordW]}
                                   - {va_ff[i][CoordW-1], va_ff[i]};
                  default: ;
               endcase
            end
            if (step_ff == 3'd3) begin
               step_in  = '0;
               state_in = mvna_pkg::S_CROSS;
            end
         end

         // six products through the shared multiplier, each used the cycle after it is issued
         mvna_pkg::S_CROSS: begin
            case (step_ff)
               3'd0: begin mul_a = e1_ff[1]; mul_b = e2_ff[2]; end
               3'd1: begin mul_a = e1_ff[2]; mul_b = e2_ff[1]; end
               3'd2: begin mul_a = e1_ff[2]; mul_b = e2_ff[0]; end
               3'd3: begin mul_a = e1_ff[0]; mul_b = e2_ff[2]; end
               3'd4: begin mul_a = e1_ff[0]; mul_b = e2_ff[1]; end
               3'd5: begin mul_a = e1_ff[1]; mul_b = e2_ff[0]; end
               default: ;
            endcase
            if (step_ff != 3'd0) begin
               if (jsel[0]) begin
                  c_in[jcomp] = c_ff[jcomp] - prod_ext;
               end else begin
                  c_in[jcomp] = prod_ext;
               end
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd6) begin
               state_in = mvna_pkg::S_MAG;
            end
         end

         mvna_pkg::S_MAG: begin
            for (int i = 0; i < 3; i++) begin
               cneg      = -c_ff[i];
               neg_in[i] = c_ff[i][CrossW-1];
               mag_in[i] = c_ff[i][CrossW-1] ? cneg[MagW-1:0] : c_ff[i][MagW-1:0];
            end
            state_in = mvna_pkg::S_NORM;
         end

         mvna_pkg::S_SUMRD: begin
            for (int i = 0; i < 3; i++) begin
               sext      = {sram_rdata[SumW*(3-i)-1], sram_rdata[SumW*(2-i) +: SumW]};
               sabs      = sext[SumW] ? -sext : sext;
               neg_in[i] = sext[SumW];
               mag_in[i] = MagW'(sabs[SumW-1:0]);
            end
            state_in = mvna_pkg::S_NORM;
         end

         // one bit per cycle until the largest magnitude sits in [2^29, 2^30); all zero goes to the response
         mvna_pkg::S_NORM: begin
            if (or_mag == '0) begin
               state_in = mvna_pkg::S_RESP;
            end else if (|or_mag[MagW-1:UnitW]) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag_ff[i] >> 1;
               end
            end else if (!or_mag[UnitW-1]) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag_ff[i] << 1;
               end
            end else begin
               step_in  = '0;
               state_in = mvna_pkg::S_SQ;
            end
         end

         mvna_pkg::S_SQ: begin
            if (step_ff < 3'd3) begin
               mul_a = EdgeW'(mag_ff[step_ff[1:0]][UnitW-1:0]);
               mul_b = EdgeW'(mag_ff[step_ff[1:0]][UnitW-1:0]);
            end
            if (step_ff == 3'd0) begin
               s_in = '0;
            end else begin
               s_in = s_ff + prod[mvna_pkg::SqW-1:0];
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd3) begin
               state_in = mvna_pkg::S_ROOT_GO;
            end
         end

         mvna_pkg::S_ROOT_GO: begin
            rdiv_cmd.start  = 1'b1;
            rdiv_cmd.is_div = 1'b0;
            state_in        = mvna_pkg::S_ROOT_WAIT;
         end

         mvna_pkg::S_ROOT_WAIT: begin
            if (rdiv_done) begin
               r_in     = rdiv_res;
               comp_in  = '0;
               state_in = mvna_pkg::S_DIV_GO;
            end
         end

         mvna_pkg::S_DIV_GO: begin
            rdiv_cmd.start  = 1'b1;
            rdiv_cmd.is_div = 1'b1;
            state_in        = mvna_pkg::S_DIV_WAIT;
         end

         mvna_pkg::S_DIV_WAIT: begin
            if (rdiv_done) begin
               if (|rdiv_res[mvna_pkg::RootW-1:NormW-1]) begin
                  qcap = mvna_pkg::QuotCap;
               end else begin
                  qcap = rdiv_res[NormW-1:0];
               end
               u_in[comp_ff] = neg_ff[comp_ff] ? -$signed(qcap) : $signed(qcap);
               comp_in       = comp_ff + 2'd1;
               if (comp_ff == 2'd2) begin
                  step_in  = '0;
                  state_in = (req_ff.action == mvna_pkg::ACT_FACE) ? mvna_pkg::S_ACC
                                                                   : mvna_pkg::S_RESP;
               end else begin
                  state_in = mvna_pkg::S_DIV_GO;
               end
            end
         end

         // read-modify-write of the three corner sums, corners are distinct
         mvna_pkg::S_ACC: begin
            if (step_ff != 3'd0) begin
               sram_we = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  sram_wdata[SumW*(2-i) +: SumW] =
                     sat_add($signed(sram_rdata[SumW*(2-i) +: SumW]), u_ff[i]);
               end
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd3) begin
               state_in = mvna_pkg::S_RESP;
            end
         end

         mvna_pkg::S_CLEAR: begin
            sram_we    = 1'b1;
            sram_waddr = clr_cnt_ff;
            sram_wdata = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == {IdxW{1'b1}}) begin
               clr_rsp_in = 1'b0;
               state_in   = clr_rsp_ff ? mvna_pkg::S_RESP : mvna_pkg::S_IDLE;
            end
         end

         mvna_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (req_ff.action == mvna_pkg::ACT_READ) begin
                  rsp_in.normal_x = u_ff[0];
                  rsp_in.normal_y = u_ff[1];
                  rsp_in.normal_z = u_ff[2];
               end else begin
                  rsp_in.normal_x = '0;
                  rsp_in.normal_y = '0;
                  rsp_in.normal_z = '0;
               end
               rsp_in.status = status_ff;
               rsp_valid_in  = 1'b1;
               state_in      = mvna_pkg::S_IDLE;
            end
         end

         default: state_in = mvna_pkg::S_IDLE;
      endcase
   end

   // control registers, reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mvna_pkg::S_CLEAR;
         clr_cnt_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vcount_ff    <= mvna_pkg::CountW'(1);
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         vcount_ff    <= vcount_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      status_ff <= status_in;
      step_ff   <= step_in;
      comp_ff   <= comp_in;
      va_ff     <= va_in;
      e1_ff     <= e1_in;
      e2_ff     <= e2_in;
      c_ff      <= c_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      s_ff      <= s_in;
      r_ff      <= r_in;
      u_ff      <= u_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- src/mvna_ram.sv -----
// generic single write port ram with registered read
module mvna_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/mvna_mul.sv -----
// shared signed multiplier with registered product
module mvna_mul (
   input  logic                              clock,
   input  logic signed [mvna_pkg::EdgeW-1:0] mul_a,
   input  logic signed [mvna_pkg::EdgeW-1:0] mul_b,
   output logic signed [mvna_pkg::ProdW-1:0] prod
);

   logic signed [mvna_pkg::ProdW-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign prod = prod_ff;

endmodule

// ----- src/mvna_rdiv.sv -----
// iterative square root and divider sharing one compare-subtract
module mvna_rdiv (
   input  logic                               clock,
   input  logic                               reset,
   input  mvna_pkg::mvna_rdiv_cmd_type        cmd,
   input  logic [mvna_pkg::SqW-1:0]           radicand,
   input  logic [mvna_pkg::NumW-1:0]          numer,
   input  logic [mvna_pkg::RootW-1:0]         denom,
   output logic                               done,
   output logic [mvna_pkg::RootW-1:0]         result
);

   localparam int W = mvna_pkg::WideW;
   localparam int LoW = mvna_pkg::NumW - mvna_pkg::QuotW;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                is_div_ff, is_div_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [W-1:0]        acc_ff, acc_in;
   logic [W-1:0]        root_ff, root_in;
   logic [W-1:0]        bit_ff, bit_in;
   logic [mvna_pkg::QuotW-1:0] nlo_ff, nlo_in;

   logic [W-1:0]        sub_a;
   logic [W-1:0]        sub_b;
   logic [W:0]          diff;
   logic                ge;
   logic [5:0]          last;

   // shared compare-subtract
   always_comb begin
      if (is_div_ff) begin
         sub_a = {acc_ff[W-2:0], nlo_ff[mvna_pkg::QuotW-1]};
         sub_b = W'(denom);
      end else begin
         sub_a = acc_ff;
         sub_b = root_ff + bit_ff;
      end
      diff = {1'b0, sub_a} - {1'b0, sub_b};
      ge   = ~diff[W];
      last = is_div_ff ? 6'(mvna_pkg::QuotW - 1) : 6'(mvna_pkg::RootW);
   end

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      is_div_in = is_div_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      root_in   = root_ff;
      bit_in    = bit_ff;
      nlo_in    = nlo_ff;
      if (cmd.start) begin
         busy_in   = 1'b1;
         is_div_in = cmd.is_div;
         cnt_in    = '0;
         acc_in    = cmd.is_div ? W'(numer[mvna_pkg::NumW-1:mvna_pkg::QuotW]) : W'(radicand);
         root_in   = '0;
         bit_in    = W'(1) << (W - 2);
         nlo_in    = numer[mvna_pkg::QuotW-1:0];
      end else if (busy_ff) begin
         if (is_div_ff) begin
            acc_in  = ge ? diff[W-1:0] : sub_a;
            root_in = {root_ff[W-2:0], ge};
            nlo_in  = {nlo_ff[mvna_pkg::QuotW-2:0], 1'b0};
         end else begin
            if (ge) begin
               acc_in  = diff[W-1:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      is_div_ff <= is_div_in;
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      root_ff   <= root_in;
      bit_ff    <= bit_in;
      nlo_ff    <= nlo_in;
   end

   assign done   = done_ff;
   assign result = root_ff[mvna_pkg::RootW-1:0];

   logic unused_lo;
   assign unused_lo = ^LoW;

endmodule
